@@ src/falp_pkg.sv @@
// Shared types and constants of the fixed pool free list allocator.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package falp_pkg;

  // Pool geometry
  localparam int POOL_ENTRIES = 64;
  localparam int HEADER_BYTES = 16;

  // Derived widths: an index addresses one entry, a link may also hold null
  localparam int IDX_W  = $clog2(POOL_ENTRIES);
  localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
  localparam int CNT_W  = 7;
  localparam int ITEM_W = 13;
  localparam int OFS_W  = 18;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Null link: one past the last entry
  localparam link_t LINK_NULL = link_t'(POOL_ENTRIES);

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POOL_EMPTY = 2'd1,
    STATUS_NOT_IN_USE = 2'd2
  } status_t;

  // Command sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LINK,
    SEQ_PUSH,
    SEQ_TERM
  } seq_state_t;

  typedef struct packed {
    logic       cmd;
    logic [5:0] entry_index;
  } in_beat_t;

  typedef struct packed {
    status_t          status;
    logic [5:0]       granted_index;
    logic [OFS_W-1:0] data_offset;
    logic [CNT_W-1:0] free_count;
  } out_beat_t;

endpackage

@@ src/fixed_pool_free_list_allocator.sv @@
// Top level of the fixed pool free list allocator: link memories, list
// heads and tails, in-use flags and the command sequencer. Imports falp_pkg.
`timescale 1ns / 1ps

// Channel   Ports                      Direction  Handshake
// input     start, busy, in_beat       in / out   beat taken when start && !busy
// result    out_valid, out_beat        out        one-cycle strobe, never stalled
// config    cfg_we, cfg_wdata          in         written when cfg_we is high
//
// A successful command steps through a read of both link memories, unlink,
// append and a final write of the entry's next link; busy is high from unlink
// to final write and the result strobes in the cycle after. The next-link
// memory, with one write port, is written up to three times per command.
// A refused command (pool empty, entry not in use) never raises busy.
// Reset is synchronous; link memory entries read as their reset links until
// first written, tracked by per-entry written flags, so no clearing pass.

module fixed_pool_free_list_allocator
  import falp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_beat_t          in_beat,
  output logic              out_valid,
  output out_beat_t         out_beat,
  input  logic              cfg_we,
  input  logic [ITEM_W-1:0] cfg_wdata
);

  localparam int PITCH_W = ITEM_W + 1;
  localparam int MUL_W   = IDX_W + PITCH_W;

  // Link memories and their written flags
  link_t                  next_mem [POOL_ENTRIES];
  link_t                  prev_mem [POOL_ENTRIES];
  link_t                  next_rd_r;
  link_t                  prev_rd_r;
  logic                   next_fresh_r;
  logic                   prev_fresh_r;
  logic [POOL_ENTRIES-1:0] next_wr_r;
  logic [POOL_ENTRIES-1:0] prev_wr_r;

  // Write ports
  logic  nx_we;
  idx_t  nx_waddr;
  link_t nx_wdata;
  logic  pv_we;
  idx_t  pv_waddr;
  link_t pv_wdata;

  // Read port, shared address
  logic rd_en;
  idx_t rd_addr;

  // List state
  seq_state_t              state_r, state_nxt;
  link_t                   free_head_r, free_head_nxt;
  link_t                   free_tail_r, free_tail_nxt;
  link_t                   used_head_r, used_head_nxt;
  link_t                   used_tail_r, used_tail_nxt;
  logic [POOL_ENTRIES-1:0] in_use_r, in_use_nxt;
  logic [CNT_W-1:0]        free_entries_r, free_entries_nxt;
  logic [ITEM_W-1:0]       item_bytes_r;

  // Command in flight
  idx_t      e_r, e_nxt;
  logic      cmd_r, cmd_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r, out_beat_nxt;

  // Decode helpers
  logic             accept;
  logic             refuse;
  link_t            idx_link;
  link_t            p_link;
  link_t            n_link;
  link_t            dst_head;
  link_t            dst_tail;
  logic [PITCH_W-1:0] pitch;
  logic [MUL_W-1:0]   ofs_full;
  logic [CNT_W-1:0]   cnt_new;

  assign busy      = (state_r != SEQ_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;
  assign idx_link  = link_t'(in_beat.entry_index);

  // Refuse an allocate on an empty pool, a return of an entry not in use
  always_comb begin
    if (in_beat.cmd == CMD_ALLOC) begin
      refuse = (free_head_r >= LINK_NULL) || (free_entries_r == '0);
    end else begin
      refuse = (idx_link >= LINK_NULL) || !in_use_r[idx_link[IDX_W-1:0]];
    end
  end

  assign rd_en   = accept && !refuse;
  assign rd_addr = (in_beat.cmd == CMD_ALLOC) ? free_head_r[IDX_W-1:0]
                                              : idx_link[IDX_W-1:0];

  // Links as read, or the reset links of an entry never written
  assign n_link = next_fresh_r ? next_rd_r : (link_t'(e_r) + link_t'(1));
  assign p_link = prev_fresh_r ? prev_rd_r
                : ((e_r == '0) ? LINK_NULL : (link_t'(e_r) - link_t'(1)));

  assign dst_head = (cmd_r == CMD_ALLOC) ? used_head_r : free_head_r;
  assign dst_tail = (cmd_r == CMD_ALLOC) ? used_tail_r : free_tail_r;

  // Payload offset of the entry
  assign pitch    = PITCH_W'(HEADER_BYTES) + PITCH_W'(item_bytes_r);
  assign ofs_full = MUL_W'(e_r) * MUL_W'(pitch) + MUL_W'(HEADER_BYTES);
  assign cnt_new  = (cmd_r == CMD_ALLOC) ? (free_entries_r - CNT_W'(1))
                                         : (free_entries_r + CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (rd_en) begin
          state_nxt = SEQ_LINK;
        end
      end
      SEQ_LINK: state_nxt = SEQ_PUSH;
      SEQ_PUSH: state_nxt = SEQ_TERM;
      SEQ_TERM: state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  // Memory writes, list updates and results per state
  always_comb begin
    free_head_nxt    = free_head_r;
    free_tail_nxt    = free_tail_r;
    used_head_nxt    = used_head_r;
    used_tail_nxt    = used_tail_r;
    in_use_nxt       = in_use_r;
    free_entries_nxt = free_entries_r;
    e_nxt            = e_r;
    cmd_nxt          = cmd_r;
    out_valid_nxt    = 1'b0;
    out_beat_nxt     = out_beat_r;
    nx_we            = 1'b0;
    nx_waddr         = e_r;
    nx_wdata         = LINK_NULL;
    pv_we            = 1'b0;
    pv_waddr         = e_r;
    pv_wdata         = LINK_NULL;
    case (state_r)
      SEQ_IDLE: begin
        if (accept) begin
          cmd_nxt = in_beat.cmd;
          e_nxt   = rd_addr;
          if (refuse) begin
            out_valid_nxt              = 1'b1;
            out_beat_nxt.status        = (in_beat.cmd == CMD_ALLOC) ? STATUS_POOL_EMPTY
                                                                    : STATUS_NOT_IN_USE;
            out_beat_nxt.granted_index = '0;
            out_beat_nxt.data_offset   = '0;
            out_beat_nxt.free_count    = free_entries_r;
          end
        end
      end
      SEQ_LINK: begin
        // Unlink the entry from its source list
        if (p_link >= LINK_NULL) begin
          if (cmd_r == CMD_ALLOC) begin
            free_head_nxt = n_link;
          end else begin
            used_head_nxt = n_link;
          end
        end else begin
          nx_we    = 1'b1;
          nx_waddr = p_link[IDX_W-1:0];
          nx_wdata = n_link;
        end
        if (n_link >= LINK_NULL) begin
          if (cmd_r == CMD_ALLOC) begin
            free_tail_nxt = p_link;
          end else begin
            used_tail_nxt = p_link;
          end
        end else begin
          pv_we    = 1'b1;
          pv_waddr = n_link[IDX_W-1:0];
          pv_wdata = p_link;
        end
      end
      SEQ_PUSH: begin
        // Append the entry to the tail of the other list
        pv_we = 1'b1;
        if ((dst_head >= LINK_NULL) || (dst_tail >= LINK_NULL)) begin
          pv_wdata = LINK_NULL;
          if (cmd_r == CMD_ALLOC) begin
            used_head_nxt = link_t'(e_r);
            used_tail_nxt = link_t'(e_r);
          end else begin
            free_head_nxt = link_t'(e_r);
            free_tail_nxt = link_t'(e_r);
          end
        end else begin
          nx_we    = 1'b1;
          nx_waddr = dst_tail[IDX_W-1:0];
          nx_wdata = link_t'(e_r);
          pv_wdata = dst_tail;
          if (cmd_r == CMD_ALLOC) begin
            used_tail_nxt = link_t'(e_r);
          end else begin
            free_tail_nxt = link_t'(e_r);
          end
        end
      end
      SEQ_TERM: begin
        // Terminate the entry's next link and report
        nx_we                      = 1'b1;
        nx_wdata                   = LINK_NULL;
        in_use_nxt[e_r]            = (cmd_r == CMD_ALLOC);
        free_entries_nxt           = cnt_new;
        out_valid_nxt              = 1'b1;
        out_beat_nxt.status        = STATUS_OK;
        out_beat_nxt.granted_index = (cmd_r == CMD_ALLOC) ? 6'(e_r) : '0;
        out_beat_nxt.data_offset   = (cmd_r == CMD_ALLOC) ? ofs_full[OFS_W-1:0] : '0;
        out_beat_nxt.free_count    = cnt_new;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Link memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
    if (rd_en) begin
      next_rd_r <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[pv_waddr] <= pv_wdata;
    end
    if (rd_en) begin
      prev_rd_r <= prev_mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= SEQ_IDLE;
      free_head_r    <= link_t'(0);
      free_tail_r    <= link_t'(POOL_ENTRIES - 1);
      used_head_r    <= LINK_NULL;
      used_tail_r    <= LINK_NULL;
      in_use_r       <= '0;
      free_entries_r <= CNT_W'(POOL_ENTRIES);
      item_bytes_r   <= ITEM_W'(8);
      next_wr_r      <= '0;
      prev_wr_r      <= '0;
      next_fresh_r   <= 1'b0;
      prev_fresh_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      free_head_r    <= free_head_nxt;
      free_tail_r    <= free_tail_nxt;
      used_head_r    <= used_head_nxt;
      used_tail_r    <= used_tail_nxt;
      in_use_r       <= in_use_nxt;
      free_entries_r <= free_entries_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        item_bytes_r <= cfg_wdata;
      end
      if (nx_we) begin
        next_wr_r[nx_waddr] <= 1'b1;
      end
      if (pv_we) begin
        prev_wr_r[pv_waddr] <= 1'b1;
      end
      if (rd_en) begin
        next_fresh_r <= next_wr_r[rd_addr];
        prev_fresh_r <= prev_wr_r[rd_addr];
      end
    end
  end

  // Payload of the command in flight and the result
  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    cmd_r      <= cmd_nxt;
    out_beat_r <= out_beat_nxt;
  end

`ifndef NO_ASSERTIONS
  // An accepted command that is not refused holds the block busy
  a_busy_after_grant: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> busy)
    else $error("busy not raised after accepted command");

  // Every finished sequence gives exactly one result strobe
  a_result_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_TERM) |=> (out_valid && !busy))
    else $error("missing result after command sequence");

  // Free count and in-use flags agree while idle
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (($countones(in_use_r) + free_entries_r) == POOL_ENTRIES))
    else $error("free count disagrees with in-use flags");

  // A refused command leaves the free count alone
  a_refuse_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && refuse) |=> $stable(free_entries_r))
    else $error("refused command changed the free count");
`endif

endmodule
